### hw/rtl/nsp_pkg.sv
// shared types and constants of the nearest sphere push-out block
`default_nettype none
package nsp_pkg;

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ACTIVE_COUNT = 2'd0,
    REG_MAX_DISTANCE = 2'd1,
    REG_INSET_MARGIN = 2'd2,
    REG_MIN_RADIUS   = 2'd3
  } reg_index_t;

  localparam logic [10:0] ACTIVE_COUNT_RST = 11'd0;
  localparam logic [30:0] MAX_DISTANCE_RST = 31'd65536000;
  localparam logic [30:0] INSET_MARGIN_RST = 31'd655360;
  localparam logic [30:0] MIN_RADIUS_RST   = 31'd6554;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // sqrt of a 64 bit value, two bits per step
  localparam int unsigned SqrtSteps = 32;
  // restoring divide of the 66 bit offset product
  localparam int unsigned DivSteps  = 66;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        radius;
    logic [31:0]        reach;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_DIFF, S_MX, S_MY, S_MZ, S_MR, S_CMP, S_SQRT, S_SURF,
    S_PSETUP, S_PMUL, S_PLOAD, S_PDIV, S_PADD, S_DONE
  } state_t;

endpackage
`default_nettype wire

### hw/rtl/nsp_ifs.sv
// handshake channels of the nearest sphere push-out block
`default_nettype none
interface nsp_item_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [9:0]         entry_index;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [30:0]        entry_radius;
  logic [30:0]        entry_pushoff;
  logic signed [31:0] query_x;
  logic signed [31:0] query_y;
  logic signed [31:0] query_z;
  modport source (output valid, op, entry_index, center_x, center_y, center_z,
                  entry_radius, entry_pushoff, query_x, query_y, query_z,
                  input ready);
  modport sink (input valid, op, entry_index, center_x, center_y, center_z,
                entry_radius, entry_pushoff, query_x, query_y, query_z,
                output ready);
endinterface

interface nsp_result_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic signed [31:0] push_x;
  logic signed [31:0] push_y;
  logic signed [31:0] push_z;
  modport source (output valid, found, push_x, push_y, push_z, input ready);
  modport sink (input valid, found, push_x, push_y, push_z, output ready);
endinterface

interface nsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/nearest_sphere_pushout.sv
// nearest sphere push-out: collider table, nearest search and push-out
//
// item channel: op 0 writes one collider entry (no result beat);
// op 1 runs a query that gives exactly one result beat.
// cfg channel: always ready; write only while the block is idle.
// a query walks entries 0..active_count-1 through one shared 33x33
// multiplier and a square root unit that takes two bits per step. an entry
// out of reach takes a read, a difference, three squares, a reach square
// and a compare; one in reach also runs the square root and a surface
// compare. the push-out then takes a setup step, per axis a multiply, a
// load, a restoring divide and an add, and a hand-off to the output
// register; with no hit or a zero length, setup skips to the hand-off.
// the item channel is not ready while a query runs. a finished result sits
// in an output register; if the receiver stalls, the next item is still
// taken, and a later query waits at its end until the register frees.
// reset clears the state, the config registers and the result valid flag;
// the table is undefined until written and needs no clearing pass.
`default_nettype none
module nearest_sphere_pushout #(
  parameter int unsigned MAX_ENTRIES = 1024
) (
  input wire logic    clk,
  input wire logic    rst,
  nsp_item_if.sink    item,
  nsp_result_if.source result,
  nsp_cfg_if.sink     cfg
);
  import nsp_pkg::*;

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  logic [10:0] active_count;
  logic [30:0] max_distance;
  logic [30:0] inset_margin;
  logic [30:0] min_radius;

  entry_t mem [MAX_ENTRIES];
  entry_t mem_q;
  logic   mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t mem_wdata;

  state_t state, state_next;
  logic [AW-1:0] idx;
  logic [CW-1:0] cnt;

  logic signed [31:0] qx, qy, qz;
  logic signed [32:0] dx, dy, dz;
  logic [32:0] mul_a, mul_b;
  logic [65:0] prod, acc;

  logic [63:0] sq_v, sq_r, sq_bit;
  logic [4:0]  sq_cnt;
  logic [64:0] sq_sum;

  logic signed [33:0] best, surf;
  logic               hit;
  logic signed [32:0] best_d [3];
  logic signed [31:0] best_c [3];
  logic [31:0]        best_len;
  logic [30:0]        best_rad;
  logic signed [32:0] push_dist;
  logic [1:0]         axis;
  logic [65:0]        dvd;
  logic [31:0]        rem;
  logic [32:0]        div_t;
  logic [6:0]         div_cnt;
  logic signed [31:0] push [3];
  logic               found_w;
  logic signed [67:0] psum;

  logic               res_valid, res_found;
  logic signed [31:0] res_x, res_y, res_z;

  logic item_acc;
  logic last_entry;
  logic out_of_reach;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  assign item.ready   = (state == S_IDLE);
  assign item_acc     = item.valid && item.ready;
  assign cfg.ready    = 1'b1;
  assign result.valid = res_valid;
  assign result.found = res_found;
  assign result.push_x = res_x;
  assign result.push_y = res_y;
  assign result.push_z = res_z;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= ACTIVE_COUNT_RST;
      max_distance <= MAX_DISTANCE_RST;
      inset_margin <= INSET_MARGIN_RST;
      min_radius   <= MIN_RADIUS_RST;
    end else if (cfg.valid) begin
      unique case (reg_index_t'(cfg.index))
        REG_ACTIVE_COUNT: active_count <= cfg.data[10:0];
        REG_MAX_DISTANCE: max_distance <= cfg.data[30:0];
        REG_INSET_MARGIN: inset_margin <= cfg.data[30:0];
        REG_MIN_RADIUS:   min_radius   <= cfg.data[30:0];
        default: ;
      endcase
    end
  end

  // entry write path with radius clamp
  always_comb begin
    logic [30:0] r;
    r = (item.entry_radius < min_radius) ? min_radius : item.entry_radius;
    mem_we = item_acc && (item.op == OP_WRITE) &&
             (32'(item.entry_index) < 32'(MAX_ENTRIES));
    mem_waddr = AW'(item.entry_index);
    mem_wdata.cx = item.center_x;
    mem_wdata.cy = item.center_y;
    mem_wdata.cz = item.center_z;
    mem_wdata.radius = r;
    mem_wdata.reach = 32'(r) + 32'(item.entry_pushoff);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[idx];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MX:   begin mul_a = mag33(dx); mul_b = mag33(dx); end
      S_MY:   begin mul_a = mag33(dy); mul_b = mag33(dy); end
      S_MZ:   begin mul_a = mag33(dz); mul_b = mag33(dz); end
      S_MR:   begin mul_a = 33'(mem_q.reach); mul_b = 33'(mem_q.reach); end
      S_PMUL: begin mul_a = mag33(best_d[axis]); mul_b = mag33(push_dist); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) prod <= mul_a * mul_b;

  assign sq_sum       = 65'(sq_r) + 65'(sq_bit);
  assign surf         = $signed({2'b00, sq_r[31:0]}) - $signed({3'b000, mem_q.radius});
  assign last_entry   = (CW'(idx) + CW'(1)) >= cnt;
  assign out_of_reach = (acc[65:64] != 2'b00) || (acc[63:0] >= prod[63:0]);
  assign div_t        = {rem, dvd[65]};
  assign psum         = 68'(best_c[axis]) +
                        ((best_d[axis][32] ^ push_dist[32]) ? -$signed({2'b00, dvd})
                                                            : $signed({2'b00, dvd}));

  // push distance: inset when deep inside, else the radius
  always_comb begin
    if ((33'(best_len) + 33'(inset_margin)) < 33'(best_rad))
      push_dist = $signed(33'(best_len)) - $signed(33'(inset_margin));
    else
      push_dist = $signed(33'(best_rad));
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_acc && item.op == OP_QUERY)
          state_next = (active_count == 11'd0) ? S_PSETUP : S_READ;
      end
      S_READ: state_next = S_DIFF;
      S_DIFF: state_next = S_MX;
      S_MX:   state_next = S_MY;
      S_MY:   state_next = S_MZ;
      S_MZ:   state_next = S_MR;
      S_MR:   state_next = S_CMP;
      S_CMP: begin
        if (out_of_reach)
          state_next = last_entry ? S_PSETUP : S_READ;
        else
          state_next = S_SQRT;
      end
      S_SQRT: if (sq_cnt == 5'(SqrtSteps - 1)) state_next = S_SURF;
      S_SURF: state_next = last_entry ? S_PSETUP : S_READ;
      S_PSETUP: state_next = (hit && best_len != 32'd0) ? S_PMUL : S_DONE;
      S_PMUL:  state_next = S_PLOAD;
      S_PLOAD: state_next = S_PDIV;
      S_PDIV:  if (div_cnt == 7'(DivSteps - 1)) state_next = S_PADD;
      S_PADD:  state_next = (axis == 2'd2) ? S_DONE : S_PMUL;
      S_DONE:  if (!res_valid || result.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath of the sequencer
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        idx  <= '0;
        cnt  <= (32'(active_count) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                      : CW'(active_count);
        best <= $signed({3'b000, max_distance});
        hit  <= 1'b0;
        qx   <= item.query_x;
        qy   <= item.query_y;
        qz   <= item.query_z;
      end
      S_DIFF: begin
        dx <= 33'(qx) - 33'(mem_q.cx);
        dy <= 33'(qy) - 33'(mem_q.cy);
        dz <= 33'(qz) - 33'(mem_q.cz);
      end
      S_MY: acc <= prod;
      S_MZ: acc <= acc + prod;
      S_MR: acc <= acc + prod;
      S_CMP: begin
        sq_v   <= acc[63:0];
        sq_r   <= '0;
        sq_bit <= 64'd1 << 62;
        sq_cnt <= '0;
        // an entry in reach keeps its address until its surface compare
        if (out_of_reach && !last_entry) idx <= idx + AW'(1);
      end
      S_SQRT: begin
        if (65'(sq_v) >= sq_sum) begin
          sq_v <= sq_v - sq_sum[63:0];
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
        sq_cnt <= sq_cnt + 5'd1;
      end
      S_SURF: begin
        // strict compare keeps the earlier entry on a tie
        if (surf < best) begin
          best      <= surf;
          hit       <= 1'b1;
          best_d[0] <= dx;
          best_d[1] <= dy;
          best_d[2] <= dz;
          best_c[0] <= mem_q.cx;
          best_c[1] <= mem_q.cy;
          best_c[2] <= mem_q.cz;
          best_len  <= sq_r[31:0];
          best_rad  <= mem_q.radius;
        end
        if (!last_entry) idx <= idx + AW'(1);
      end
      S_PSETUP: begin
        axis    <= 2'd0;
        found_w <= hit;
        if (!hit) begin
          push[0] <= '0;
          push[1] <= '0;
          push[2] <= '0;
        end else begin
          push[0] <= best_c[0];
          push[1] <= best_c[1];
          push[2] <= best_c[2];
        end
      end
      S_PLOAD: begin
        dvd     <= prod;
        rem     <= '0;
        div_cnt <= '0;
      end
      S_PDIV: begin
        if (div_t >= 33'(best_len)) begin
          rem <= 32'(div_t - 33'(best_len));
          dvd <= {dvd[64:0], 1'b1};
        end else begin
          rem <= div_t[31:0];
          dvd <= {dvd[64:0], 1'b0};
        end
        div_cnt <= div_cnt + 7'd1;
      end
      S_PADD: begin
        if (psum > 68'sh7FFF_FFFF)       push[axis] <= 32'sh7FFF_FFFF;
        else if (psum < -68'sh8000_0000) push[axis] <= -32'sh8000_0000;
        else                             push[axis] <= psum[31:0];
        axis <= axis + 2'd1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_DONE && (!res_valid || result.ready)) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!res_valid || result.ready)) begin
      res_found <= found_w;
      res_x     <= push[0];
      res_y     <= push[1];
      res_z     <= push[2];
    end
  end

endmodule
`default_nettype wire
